>>> sv/fcts_pkg.sv
// Shared types and constants for the framed command two-axis stepper unit.
package fcts_pkg;

    // Frame delimiters
    localparam logic [7:0] FRAME_START = 8'hFF;
    localparam logic [7:0] FRAME_END   = 8'hFE;

    // Command codes
    localparam logic [7:0] CMD_GOTO_X  = 8'h01;
    localparam logic [7:0] CMD_GOTO_Y  = 8'h02;
    localparam logic [7:0] CMD_FIRE    = 8'h03;
    localparam logic [7:0] CMD_ARM     = 8'h04;
    localparam logic [7:0] CMD_DISARM  = 8'h05;

    // Configuration register indexes
    localparam logic CFG_STEP_INTERVAL = 1'b0;
    localparam logic CFG_RELOAD_TIME   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [15:0] STEP_INTERVAL_RST = 16'd400;
    localparam logic [23:0] RELOAD_TIME_RST   = 24'd400000;

    // Counter saturation limits
    localparam logic [15:0] SINCE_STEP_MAX = 16'hFFFF;
    localparam logic [23:0] SINCE_SHOT_MAX = 24'hFFFFFF;

    // Result word width (38 bits of fields, padded to whole bytes)
    localparam int RESULT_W = 40;

    // Receive parser phase
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_CMD   = 3'd1,
        PH_MSB   = 3'd2,
        PH_LSB   = 3'd3,
        PH_END   = 3'd4
    } rx_phase_t;

    // Decoded command strobes from a completed frame
    typedef struct packed {
        logic        move_x;
        logic        move_y;
        logic        fire;
        logic        arm;
        logic        disarm;
        logic [15:0] value;
    } cmd_t;

    // Per-axis result of one item
    typedef struct packed {
        logic        step;
        logic        dir;
        logic [15:0] pos;
    } axis_out_t;

endpackage

>>> sv/fcts_parser.sv
// Serial frame parser: FF, command, optional big-endian value, FE.
module fcts_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output fcts_pkg::cmd_t       cmd
);
    import fcts_pkg::*;

    rx_phase_t   phase_reg, phase_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] value_reg, value_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            command_reg <= 8'd0;
            high_reg    <= 8'd0;
            value_reg   <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            high_reg    <= high_next;
            value_reg   <= value_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        high_next    = high_reg;
        value_next   = value_reg;
        cmd          = '0;
        cmd.value    = value_reg;
        if (byte_en)
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    command_next = rx_byte;
                    if (rx_byte == CMD_GOTO_X || rx_byte == CMD_GOTO_Y)
                    begin
                        phase_next = PH_MSB;
                    end
                    else
                    begin
                        value_next = 16'd0;
                        phase_next = PH_END;
                    end
                end
                PH_MSB:
                begin
                    high_next  = rx_byte;
                    phase_next = PH_LSB;
                end
                PH_LSB:
                begin
                    value_next = {high_reg, rx_byte};
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    // a good end byte runs the command; any byte ends the frame
                    if (rx_byte == FRAME_END)
                    begin
                        cmd.move_x = (command_reg == CMD_GOTO_X);
                        cmd.move_y = (command_reg == CMD_GOTO_Y);
                        cmd.fire   = (command_reg == CMD_FIRE);
                        cmd.arm    = (command_reg == CMD_ARM);
                        cmd.disarm = (command_reg == CMD_DISARM);
                    end
                    phase_next   = PH_START;
                    command_next = 8'd0;
                    value_next   = 16'd0;
                end
                default:
                begin
                    phase_next = (rx_byte == FRAME_START) ? PH_CMD : PH_START;
                end
            endcase
        end
    end

endmodule

>>> sv/fcts_axis.sv
// One stepper axis: interval counter, target tracking and optional limit stop.
module fcts_axis (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_en,
    input  logic                  load_en,
    input  logic [15:0]           load_goal,
    input  logic [15:0]           step_interval,
    input  logic                  limited,
    input  logic                  back_pressed,
    input  logic                  front_pressed,
    output fcts_pkg::axis_out_t   result
);
    import fcts_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] goal_reg, goal_next;
    logic [15:0] since_reg, since_next;
    logic        dir_reg, dir_next;

    logic [15:0] since_inc;
    logic        due;
    logic        positive;
    logic        blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 16'd0;
            goal_reg  <= 16'd0;
            since_reg <= 16'd0;
            dir_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            goal_reg  <= goal_next;
            since_reg <= since_next;
            dir_reg   <= dir_next;
        end
    end

    // Step decision for this tick
    assign since_inc = (since_reg == SINCE_STEP_MAX) ? since_reg : since_reg + 16'd1;
    assign due       = (pos_reg != goal_reg) && (since_inc >= step_interval);
    assign positive  = $signed(pos_reg) < $signed(goal_reg);
    assign blocked   = limited && ((positive && front_pressed) || (!positive && back_pressed));

    always_comb
    begin
        pos_next    = pos_reg;
        goal_next   = goal_reg;
        since_next  = since_reg;
        dir_next    = dir_reg;
        result.step = 1'b0;
        if (load_en)
        begin
            pos_next  = 16'd0;
            goal_next = load_goal;
        end
        else if (tick_en)
        begin
            since_next = due ? 16'd0 : since_inc;
            if (due)
            begin
                if (blocked)
                begin
                    // limit switch pressed: hold here as the new target
                    goal_next = pos_reg;
                end
                else
                begin
                    result.step = 1'b1;
                    dir_next    = !positive;
                    pos_next    = positive ? pos_reg + 16'd1 : pos_reg - 16'd1;
                end
            end
        end
        result.dir = dir_next;
        result.pos = pos_next;
    end

endmodule

>>> sv/framed_command_two_axis_stepper_unit.sv
// Top level: input register, frame parser, two axes, trigger and result register.
// An input transfer passes through the input register, then the result register, before
// its earliest result transfer; state updates as the result register loads.
// Throughput: one item per cycle while the result register is not held by m_axis_tready low.
// Reset: parser waits for a start byte, positions, targets and counters are zero,
// gun disarmed, trigger reloaded, step_interval 400 and reload_time 400000.
module framed_command_two_axis_stepper_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], limit_back_pressed[8],
                                        // limit_front_pressed[9], zero [15:10]
    input  logic        s_axis_tuser,   // kind[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // step_x[0], dir_x[1], step_y[2], dir_y[3],
                                        // gun_enable_out[4], trigger_shot[5],
                                        // position_x[21:6], position_y[37:22], zero [39:38]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);
    import fcts_pkg::*;

    // Configuration registers
    logic [15:0] step_interval_reg;
    logic [23:0] reload_time_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [7:0]  in_byte_reg;
    logic        in_back_reg;
    logic        in_front_reg;

    // Result register
    logic                out_valid_reg;
    logic [RESULT_W-1:0] out_data_reg, out_data_next;

    // Trigger state
    logic        armed_reg, armed_next;
    logic        reloaded_reg, reloaded_next;
    logic [23:0] since_shot_reg, since_shot_next;
    logic [23:0] since_shot_inc;

    logic      process;
    logic      byte_en;
    logic      tick_en;
    cmd_t      cmd;
    axis_out_t x_out;
    axis_out_t y_out;

    // Handshakes
    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;
    assign byte_en       = process && !in_kind_reg;
    assign tick_en       = process && in_kind_reg;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_interval_reg <= STEP_INTERVAL_RST;
            reload_time_reg   <= RELOAD_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_INTERVAL: step_interval_reg <= cfg_data[15:0];
                CFG_RELOAD_TIME:   reload_time_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_kind_reg  <= s_axis_tuser;
            in_byte_reg  <= s_axis_tdata[7:0];
            in_back_reg  <= s_axis_tdata[8];
            in_front_reg <= s_axis_tdata[9];
        end
    end

    fcts_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (in_byte_reg),
        .cmd     (cmd)
    );

    fcts_axis u_axis_x (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_en),
        .load_en       (cmd.move_x),
        .load_goal     (cmd.value),
        .step_interval (step_interval_reg),
        .limited       (1'b0),
        .back_pressed  (in_back_reg),
        .front_pressed (in_front_reg),
        .result        (x_out)
    );

    fcts_axis u_axis_y (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_en),
        .load_en       (cmd.move_y),
        .load_goal     (cmd.value),
        .step_interval (step_interval_reg),
        .limited       (1'b1),
        .back_pressed  (in_back_reg),
        .front_pressed (in_front_reg),
        .result        (y_out)
    );

    // Trigger: arm, fire and reload timing
    assign since_shot_inc = (since_shot_reg == SINCE_SHOT_MAX) ? since_shot_reg
                                                               : since_shot_reg + 24'd1;

    always_comb
    begin
        armed_next      = armed_reg;
        reloaded_next   = reloaded_reg;
        since_shot_next = since_shot_reg;
        if (byte_en)
        begin
            if (cmd.fire && armed_reg && reloaded_reg)
            begin
                reloaded_next   = 1'b0;
                since_shot_next = 24'd0;
            end
            if (cmd.arm)
            begin
                armed_next = 1'b1;
            end
            if (cmd.disarm)
            begin
                armed_next = 1'b0;
            end
        end
        else if (tick_en && !reloaded_reg)
        begin
            since_shot_next = since_shot_inc;
            if (since_shot_inc >= reload_time_reg)
            begin
                reloaded_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            reloaded_reg   <= 1'b1;
            since_shot_reg <= 24'd0;
        end
        else
        begin
            armed_reg      <= armed_next;
            reloaded_reg   <= reloaded_next;
            since_shot_reg <= since_shot_next;
        end
    end

    // Result word
    assign out_data_next = {2'b00, y_out.pos, x_out.pos, !reloaded_next, armed_next,
                            y_out.dir, y_out.step, x_out.dir, x_out.step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
